[rtl/core/sqvg_pkg.sv]
// ----------------------------------------------------------------------------
// sqvg_pkg
// Types, widths and codes shared by the shape quad vertex generator.
// ----------------------------------------------------------------------------
package sqvg_pkg;

	// fixed field widths
	localparam int COORD_W = 24;
	localparam int SIZE_W  = 23;
	localparam int TEX_W   = 24;

	// internal widths, sized for the worst geometry of a rounded rectangle
	localparam int GEO_W = 27;
	localparam int NUM_W = 30;
	localparam int DEN_W = 27;

	// divider organization
	localparam int Q_W            = 24;
	localparam int DIV_STEPS      = 4;
	localparam int DIV_STAGES     = Q_W / DIV_STEPS;
	localparam int DIV_LAT        = DIV_STAGES + 3;

	localparam logic signed [TEX_W-1:0] S24_MAX = 24'sh7FFFFF;
	localparam logic signed [TEX_W-1:0] S24_MIN = 24'sh800000;

	// request codes
	localparam logic [2:0] FUNC_RECT          = 3'd0;
	localparam logic [2:0] FUNC_ELLIPSE       = 3'd1;
	localparam logic [2:0] FUNC_RECT_SLICE    = 3'd2;
	localparam logic [2:0] FUNC_ELLIPSE_SLICE = 3'd3;
	localparam logic [2:0] FUNC_ROUNDED       = 3'd4;

	localparam logic LIST_RECT    = 1'b0;
	localparam logic LIST_ELLIPSE = 1'b1;

	// vertex order inside a quad
	localparam logic [1:0] CORNER_RT = 2'd0;
	localparam logic [1:0] CORNER_RB = 2'd1;
	localparam logic [1:0] CORNER_LB = 2'd2;
	localparam logic [1:0] CORNER_LT = 2'd3;

	localparam logic [4:0] VTX_LAST_QUAD    = 5'd3;
	localparam logic [4:0] VTX_LAST_ROUNDED = 5'd27;

	typedef struct packed {
		logic                    valid;
		logic                    list;
		logic signed [GEO_W-1:0] sx;
		logic signed [GEO_W-1:0] sy;
		logic signed [GEO_W-1:0] sw;
		logic signed [GEO_W-1:0] sh;
		logic signed [GEO_W-1:0] rx;
		logic signed [GEO_W-1:0] ry;
		logic signed [GEO_W-1:0] rw;
		logic signed [GEO_W-1:0] rh;
		logic [SIZE_W-1:0]       th;
		logic [1:0]              corner;
		logic                    run_end;
	} geo_t;

	typedef struct packed {
		logic                    valid;
		logic                    list;
		logic [COORD_W-1:0]      pos_x;
		logic [COORD_W-1:0]      pos_y;
		logic signed [NUM_W-1:0] num_x;
		logic signed [NUM_W-1:0] num_y;
		logic signed [DEN_W-1:0] den_xu;
		logic signed [DEN_W-1:0] den_xs;
		logic signed [DEN_W-1:0] den_yu;
		logic signed [DEN_W-1:0] den_ys;
		logic                    prim_end;
		logic                    run_end;
	} prep_t;

	typedef struct packed {
		logic               valid;
		logic               list;
		logic [COORD_W-1:0] pos_x;
		logic [COORD_W-1:0] pos_y;
		logic               prim_end;
		logic               run_end;
	} side_t;

	function automatic logic [COORD_W-1:0] sat_coord(input logic signed [GEO_W:0] v);
		logic signed [GEO_W:0] hi;
		logic signed [GEO_W:0] lo;
		logic [COORD_W-1:0]    r;
		hi = (GEO_W+1)'(S24_MAX);
		lo = (GEO_W+1)'(S24_MIN);
		if (v > hi) begin
			r = S24_MAX;
		end else if (v < lo) begin
			r = S24_MIN;
		end else begin
			r = v[COORD_W-1:0];
		end
		return r;
	endfunction

endpackage

[rtl/core/sqvg_seq.sv]
// ----------------------------------------------------------------------------
// sqvg_seq
// Request holder and vertex sequencer: one vertex descriptor per cycle unless stalled.
// ----------------------------------------------------------------------------
module sqvg_seq (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                advance,
	input  logic                                req_valid,
	output logic                                req_ready,
	input  logic [2:0]                          func,
	input  logic signed [sqvg_pkg::COORD_W-1:0] rect_x,
	input  logic signed [sqvg_pkg::COORD_W-1:0] rect_y,
	input  logic [sqvg_pkg::SIZE_W-1:0]         rect_w,
	input  logic [sqvg_pkg::SIZE_W-1:0]         rect_h,
	input  logic signed [sqvg_pkg::COORD_W-1:0] slice_x,
	input  logic signed [sqvg_pkg::COORD_W-1:0] slice_y,
	input  logic [sqvg_pkg::SIZE_W-1:0]         slice_w,
	input  logic [sqvg_pkg::SIZE_W-1:0]         slice_h,
	input  logic [sqvg_pkg::SIZE_W-1:0]         corner_radius,
	input  logic [sqvg_pkg::SIZE_W-1:0]         stroke_width,
	output sqvg_pkg::geo_t                      geo_s1
);

	localparam int GW = sqvg_pkg::GEO_W;

	logic [2:0]                          func_q;
	logic signed [sqvg_pkg::COORD_W-1:0] x_q, y_q, sx_q, sy_q;
	logic [sqvg_pkg::SIZE_W-1:0]         w_q, h_q, sw_q, sh_q, r_q, th_q;
	logic                                busy_q;
	logic [4:0]                          vtx_q;
	logic                                last_vtx;
	logic                                accept;
	logic                                known;
	logic [2:0]                          quad;
	sqvg_pkg::geo_t                      geo_c;
	logic signed [GW-1:0]                xe, ye, we, he, sxe, sye, swe, she, re, rre;

	assign last_vtx  = (func_q == sqvg_pkg::FUNC_ROUNDED) ? (vtx_q == sqvg_pkg::VTX_LAST_ROUNDED)
	                                                      : (vtx_q == sqvg_pkg::VTX_LAST_QUAD);
	assign req_ready = advance && (!busy_q || last_vtx);
	assign accept    = req_valid && req_ready;
	assign known     = (func <= sqvg_pkg::FUNC_ROUNDED);
	assign quad      = vtx_q[4:2];

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= func;
			x_q    <= rect_x;
			y_q    <= rect_y;
			w_q    <= rect_w;
			h_q    <= rect_h;
			sx_q   <= slice_x;
			sy_q   <= slice_y;
			sw_q   <= slice_w;
			sh_q   <= slice_h;
			r_q    <= corner_radius;
			th_q   <= stroke_width;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			vtx_q  <= '0;
		end else if (accept) begin
			busy_q <= known;
			vtx_q  <= '0;
		end else if (advance && busy_q) begin
			if (last_vtx) begin
				busy_q <= 1'b0;
			end else begin
				vtx_q <= vtx_q + 5'd1;
			end
		end
	end

	assign xe  = GW'(x_q);
	assign ye  = GW'(y_q);
	assign sxe = GW'(sx_q);
	assign sye = GW'(sy_q);
	assign we  = GW'({1'b0, w_q});
	assign he  = GW'({1'b0, h_q});
	assign swe = GW'({1'b0, sw_q});
	assign she = GW'({1'b0, sh_q});
	assign re  = GW'({1'b0, r_q});
	assign rre = re <<< 1;

	always_comb begin
		geo_c         = '0;
		geo_c.valid   = busy_q;
		geo_c.th      = th_q;
		geo_c.corner  = vtx_q[1:0];
		geo_c.run_end = last_vtx;
		geo_c.rx      = xe;
		geo_c.ry      = ye;
		geo_c.rw      = we;
		geo_c.rh      = he;
		geo_c.sx      = xe;
		geo_c.sy      = ye;
		geo_c.sw      = we;
		geo_c.sh      = he;
		case (func_q)
			sqvg_pkg::FUNC_RECT, sqvg_pkg::FUNC_ELLIPSE: begin
				geo_c.list = func_q[0];
			end
			sqvg_pkg::FUNC_RECT_SLICE, sqvg_pkg::FUNC_ELLIPSE_SLICE: begin
				geo_c.list = func_q[0];
				geo_c.sx   = sxe;
				geo_c.sy   = sye;
				geo_c.sw   = swe;
				geo_c.sh   = she;
			end
			sqvg_pkg::FUNC_ROUNDED: begin
				// corner ellipses first, then the three straight bands
				if (!quad[2]) begin
					geo_c.list = sqvg_pkg::LIST_ELLIPSE;
					geo_c.sw   = re;
					geo_c.sh   = re;
					geo_c.rw   = rre;
					geo_c.rh   = rre;
					if (quad[0]) begin
						geo_c.sx = xe + we - re;
						geo_c.rx = xe + we - rre;
					end
					if (quad[1]) begin
						geo_c.sy = ye + he - re;
						geo_c.ry = ye + he - rre;
					end
				end else begin
					geo_c.list = sqvg_pkg::LIST_RECT;
					case (quad[1:0])
						2'd0: begin
							geo_c.sx = xe + re;
							geo_c.sw = we - rre;
							geo_c.sh = re;
						end
						2'd1: begin
							geo_c.sx = xe + re;
							geo_c.sy = ye + he - re;
							geo_c.sw = we - rre;
							geo_c.sh = re;
						end
						default: begin
							geo_c.sy = ye + re;
							geo_c.sh = he - rre;
						end
					endcase
				end
			end
			default: begin
				geo_c.list = sqvg_pkg::LIST_RECT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			geo_s1 <= '0;
		end else if (advance) begin
			geo_s1 <= geo_c;
		end
	end

endmodule

[rtl/core/sqvg_prep.sv]
// ----------------------------------------------------------------------------
// sqvg_prep
// Per-vertex positions, texture numerators and divisors.
// ----------------------------------------------------------------------------
module sqvg_prep (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           advance,
	input  sqvg_pkg::geo_t geo_s1,
	output sqvg_pkg::prep_t prep_s2
);

	localparam int GW = sqvg_pkg::GEO_W;
	localparam int NW = sqvg_pkg::NUM_W;
	localparam int DW = sqvg_pkg::DEN_W;

	logic                 right, bottom;
	logic signed [GW:0]   px, ey;
	logic signed [NW-1:0] dx, dy;
	logic signed [DW-1:0] th2;
	sqvg_pkg::prep_t      prep_c;

	assign right  = (geo_s1.corner == sqvg_pkg::CORNER_RT) || (geo_s1.corner == sqvg_pkg::CORNER_RB);
	assign bottom = (geo_s1.corner == sqvg_pkg::CORNER_RB) || (geo_s1.corner == sqvg_pkg::CORNER_LB);

	assign px  = (GW+1)'(geo_s1.sx) + (right ? (GW+1)'(geo_s1.sw) : '0);
	assign ey  = (GW+1)'(geo_s1.sy) + (bottom ? (GW+1)'(geo_s1.sh) : '0);
	assign dx  = NW'(px) - NW'(geo_s1.rx);
	assign dy  = NW'(ey) - NW'(geo_s1.ry);
	assign th2 = DW'({1'b0, geo_s1.th, 1'b0});

	always_comb begin
		prep_c          = '0;
		prep_c.valid    = geo_s1.valid;
		prep_c.list     = geo_s1.list;
		prep_c.pos_x    = sqvg_pkg::sat_coord(px);
		prep_c.pos_y    = sqvg_pkg::sat_coord(-ey);
		prep_c.num_x    = (dx <<< 1) - NW'(geo_s1.rw);
		prep_c.num_y    = (dy <<< 1) - NW'(geo_s1.rh);
		prep_c.den_xu   = DW'(geo_s1.rw);
		prep_c.den_yu   = DW'(geo_s1.rh);
		prep_c.den_xs   = DW'(geo_s1.rw) - th2;
		prep_c.den_ys   = DW'(geo_s1.rh) - th2;
		prep_c.prim_end = (geo_s1.corner == sqvg_pkg::CORNER_LT);
		prep_c.run_end  = geo_s1.run_end && (geo_s1.corner == sqvg_pkg::CORNER_LT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prep_s2 <= '0;
		end else if (advance) begin
			prep_s2 <= prep_c;
		end
	end

endmodule

[rtl/core/sqvg_div.sv]
// ----------------------------------------------------------------------------
// sqvg_div
// Pipelined rounding divider: round(num * 2^FRAC / den), saturated to 24 bits.
// ----------------------------------------------------------------------------
module sqvg_div #(
	parameter int FRAC = 16
) (
	input  logic                                clk,
	input  logic                                en,
	input  logic signed [sqvg_pkg::NUM_W-1:0]   num,
	input  logic signed [sqvg_pkg::DEN_W-1:0]   den,
	output logic [sqvg_pkg::TEX_W-1:0]          q
);

	localparam int NW  = sqvg_pkg::NUM_W;
	localparam int DW  = sqvg_pkg::DEN_W;
	localparam int QW  = sqvg_pkg::Q_W;
	localparam int XW  = NW + FRAC + 2;
	localparam int DDW = DW + 1;
	localparam int NST = sqvg_pkg::DIV_STAGES;
	localparam int NSP = sqvg_pkg::DIV_STEPS;

	typedef struct packed {
		logic neg;
		logic zero;
		logic npos;
		logic nneg;
		logic ovf;
	} div_flags_t;

	div_flags_t       flags_s1;
	logic [NW-1:0]    an_s1;
	logic [DW-1:0]    ad_s1;

	logic [XW-1:0]    nfull;
	logic [XW-1:0]    nhi;
	logic [DDW-1:0]   dfull;

	div_flags_t       flags_s [0:NST];
	logic [DDW-1:0]   rem_s   [0:NST];
	logic [QW-1:0]    nlo_s   [0:NST];
	logic [QW-1:0]    quo_s   [0:NST];
	logic [DDW-1:0]   d_s     [0:NST];

	// sign handling and magnitudes
	always_ff @(posedge clk) begin
		if (en) begin
			flags_s1 <= {num[NW-1] ^ den[DW-1], den == '0, !num[NW-1] && (num != '0),
				num[NW-1], 1'b0};
			an_s1 <= num[NW-1] ? NW'(-num) : NW'(num);
			ad_s1 <= den[DW-1] ? DW'(-den) : DW'(den);
		end
	end

	// (|n| * 2^(FRAC+1) + |d|) / (2|d|); a quotient of 2^23 or more only saturates
	assign nfull = (XW'(an_s1) << (FRAC + 1)) + XW'(ad_s1);
	assign dfull = {ad_s1, 1'b0};
	assign nhi   = nfull >> QW;

	always_ff @(posedge clk) begin
		if (en) begin
			flags_s[0] <= {flags_s1.neg, flags_s1.zero, flags_s1.npos, flags_s1.nneg,
				nhi >= XW'(dfull)};
			rem_s[0]   <= DDW'(nhi);
			nlo_s[0]   <= nfull[QW-1:0];
			quo_s[0]   <= '0;
			d_s[0]     <= dfull;
		end
	end

	for (genvar k = 0; k < NST; k++) begin : g_stage
		logic [DDW-1:0] rem_c;
		logic [QW-1:0]  nlo_c;
		logic [QW-1:0]  quo_c;

		always_comb begin
			logic [DDW:0] trial;
			rem_c = rem_s[k];
			nlo_c = nlo_s[k];
			quo_c = quo_s[k];
			for (int j = 0; j < NSP; j++) begin
				trial = {rem_c, nlo_c[QW-1]};
				nlo_c = nlo_c << 1;
				if (trial >= (DDW+1)'(d_s[k])) begin
					trial = trial - (DDW+1)'(d_s[k]);
					quo_c = {quo_c[QW-2:0], 1'b1};
				end else begin
					quo_c = {quo_c[QW-2:0], 1'b0};
				end
				rem_c = trial[DDW-1:0];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				flags_s[k+1] <= flags_s[k];
				rem_s[k+1]   <= rem_c;
				nlo_s[k+1]   <= nlo_c;
				quo_s[k+1]   <= quo_c;
				d_s[k+1]     <= d_s[k];
			end
		end
	end

	logic       big;
	div_flags_t fl;
	logic [QW-1:0] qv;

	assign fl  = flags_s[NST];
	assign qv  = quo_s[NST];
	assign big = fl.ovf || qv[QW-1];

	always_ff @(posedge clk) begin
		if (en) begin
			if (fl.zero) begin
				q <= fl.npos ? sqvg_pkg::S24_MAX : (fl.nneg ? sqvg_pkg::S24_MIN : '0);
			end else if (fl.neg) begin
				q <= big ? sqvg_pkg::S24_MIN : -qv;
			end else begin
				q <= big ? sqvg_pkg::S24_MAX : qv;
			end
		end
	end

endmodule

[rtl/core/shape_quad_vertex_generator_top.sv]
// ----------------------------------------------------------------------------
// shape_quad_vertex_generator_top
// Quad vertex generator for an outline-aware shape shader.
// ----------------------------------------------------------------------------
// The block emits one vertex per cycle unless the vertex side stalls: a
// rectangle, ellipse or slice request gives 4 vertices and a rounded
// rectangle 28, set by the sequencer that walks the vertices of a request
// one at a time; an unknown func is taken and emits nothing. The next
// request is taken in the cycle its predecessor's last vertex leaves the
// sequencer. The first vertex passes through the sequencer, vertex setup
// and four nine-stage pipelined dividers running side by side for the
// texture values. A stall on the vertex side holds the whole pipeline.
// ----------------------------------------------------------------------------
module shape_quad_vertex_generator_top #(
	parameter int TEX_FRAC_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	output logic                                req_ready,
	input  logic [2:0]                          func,
	input  logic signed [sqvg_pkg::COORD_W-1:0] rect_x,
	input  logic signed [sqvg_pkg::COORD_W-1:0] rect_y,
	input  logic [sqvg_pkg::SIZE_W-1:0]         rect_w,
	input  logic [sqvg_pkg::SIZE_W-1:0]         rect_h,
	input  logic signed [sqvg_pkg::COORD_W-1:0] slice_x,
	input  logic signed [sqvg_pkg::COORD_W-1:0] slice_y,
	input  logic [sqvg_pkg::SIZE_W-1:0]         slice_w,
	input  logic [sqvg_pkg::SIZE_W-1:0]         slice_h,
	input  logic [sqvg_pkg::SIZE_W-1:0]         corner_radius,
	input  logic [sqvg_pkg::SIZE_W-1:0]         stroke_width,
	output logic                                vtx_valid,
	input  logic                                vtx_ready,
	output logic                                list_select,
	output logic signed [sqvg_pkg::COORD_W-1:0] pos_x,
	output logic signed [sqvg_pkg::COORD_W-1:0] pos_y,
	output logic signed [sqvg_pkg::TEX_W-1:0]   scaled_u,
	output logic signed [sqvg_pkg::TEX_W-1:0]   scaled_v,
	output logic signed [sqvg_pkg::TEX_W-1:0]   unit_u,
	output logic signed [sqvg_pkg::TEX_W-1:0]   unit_v,
	output logic                                primitive_end,
	output logic                                run_end
);

	localparam int LAT = sqvg_pkg::DIV_LAT;

	logic             advance;
	sqvg_pkg::geo_t   geo_s1;
	sqvg_pkg::prep_t  prep_s2;
	sqvg_pkg::side_t  side_s [0:LAT-1];
	logic [sqvg_pkg::TEX_W-1:0] xs_q, ys_q, xu_q, yu_q;

	// the output register is the last pipeline stage
	assign advance = !vtx_valid || vtx_ready;

	sqvg_seq u_seq (
		.clk               (clk),
		.arst_n            (arst_n),
		.advance           (advance),
		.req_valid         (req_valid),
		.req_ready         (req_ready),
		.func              (func),
		.rect_x            (rect_x),
		.rect_y            (rect_y),
		.rect_w            (rect_w),
		.rect_h            (rect_h),
		.slice_x           (slice_x),
		.slice_y           (slice_y),
		.slice_w           (slice_w),
		.slice_h           (slice_h),
		.corner_radius     (corner_radius),
		.stroke_width      (stroke_width),
		.geo_s1            (geo_s1)
	);

	sqvg_prep u_prep (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.geo_s1  (geo_s1),
		.prep_s2 (prep_s2)
	);

	sqvg_div #(.FRAC(TEX_FRAC_BITS)) u_div_xs (
		.clk (clk), .en (advance), .num (prep_s2.num_x), .den (prep_s2.den_xs), .q (xs_q)
	);
	sqvg_div #(.FRAC(TEX_FRAC_BITS)) u_div_ys (
		.clk (clk), .en (advance), .num (prep_s2.num_y), .den (prep_s2.den_ys), .q (ys_q)
	);
	sqvg_div #(.FRAC(TEX_FRAC_BITS)) u_div_xu (
		.clk (clk), .en (advance), .num (prep_s2.num_x), .den (prep_s2.den_xu), .q (xu_q)
	);
	sqvg_div #(.FRAC(TEX_FRAC_BITS)) u_div_yu (
		.clk (clk), .en (advance), .num (prep_s2.num_y), .den (prep_s2.den_yu), .q (yu_q)
	);

	// side fields travel beside the dividers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < LAT; k++) begin
				side_s[k] <= '0;
			end
		end else if (advance) begin
			side_s[0] <= {prep_s2.valid, prep_s2.list, prep_s2.pos_x, prep_s2.pos_y,
				prep_s2.prim_end, prep_s2.run_end};
			for (int k = 1; k < LAT; k++) begin
				side_s[k] <= side_s[k-1];
			end
		end
	end

	assign vtx_valid     = side_s[LAT-1].valid;
	assign list_select   = side_s[LAT-1].list;
	assign pos_x         = side_s[LAT-1].pos_x;
	assign pos_y         = side_s[LAT-1].pos_y;
	assign primitive_end = side_s[LAT-1].prim_end;
	assign run_end       = side_s[LAT-1].run_end;
	assign scaled_u      = xs_q;
	assign scaled_v      = ys_q;
	assign unit_u        = xu_q;
	assign unit_v        = yu_q;

	// a run always closes on the last vertex of a quad
	a_run_end_on_quad_end: assert property (@(posedge clk) disable iff (!arst_n)
		vtx_valid && run_end |-> primitive_end)
		else $error("run end outside quad end");

	// a stalled vertex descriptor is held, not dropped
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		geo_s1.valid && !advance |=> geo_s1.valid)
		else $error("vertex descriptor lost under stall");

	// no new request is taken while the pipeline is stalled
	a_no_accept_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |-> advance)
		else $error("request taken while pipeline stalled");

endmodule

[sim/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives shape requests into the quad vertex generator and checks every vertex
// against a local predictor. A short table of directed requests runs first.
// Random requests follow, with random idling on both channels and one long
// vertex-side hold-off.
// ----------------------------------------------------------------------------
module testbench;

	localparam int  N_RANDOM  = 400;
	localparam int  IDLE_MAX  = 6000;
	localparam int  HOLD_LEN  = 400;
	localparam longint SMAX   = 8388607;
	localparam longint SMIN   = -8388608;

	typedef struct {
		logic [2:0]          func;
		logic signed [23:0]  x, y;
		logic [22:0]         w, h;
		logic signed [23:0]  sx, sy;
		logic [22:0]         sw, sh, r, th;
	} shape_req_t;

	typedef struct {
		logic                list;
		logic signed [23:0]  px, py, su, sv, uu, uv;
		logic                pend, rend;
	} vertex_t;

	typedef struct {
		shape_req_t req;
		bit         has_exp;
		vertex_t    first;
	} table_row_t;

	logic clk;
	logic arst_n;
	logic req_valid, req_ready;
	logic [2:0] func;
	logic signed [23:0] rect_x, rect_y, slice_x, slice_y;
	logic [22:0] rect_w, rect_h, slice_w, slice_h, corner_radius, stroke_width;
	logic vtx_valid, vtx_ready;
	logic list_select, primitive_end, run_end;
	logic signed [23:0] pos_x, pos_y, scaled_u, scaled_v, unit_u, unit_v;

	vertex_t    pending_vertices[$];
	table_row_t directed[$];
	int         fails = 0;
	int         idle_cycles = 0;

	shape_quad_vertex_generator_top DUT (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready),
		.func(func), .rect_x(rect_x), .rect_y(rect_y), .rect_w(rect_w), .rect_h(rect_h),
		.slice_x(slice_x), .slice_y(slice_y), .slice_w(slice_w), .slice_h(slice_h),
		.corner_radius(corner_radius), .stroke_width(stroke_width),
		.vtx_valid(vtx_valid), .vtx_ready(vtx_ready),
		.list_select(list_select), .pos_x(pos_x), .pos_y(pos_y),
		.scaled_u(scaled_u), .scaled_v(scaled_v), .unit_u(unit_u), .unit_v(unit_v),
		.primitive_end(primitive_end), .run_end(run_end)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic longint clamp24(longint v);
		if (v > SMAX) begin
			return SMAX;
		end
		if (v < SMIN) begin
			return SMIN;
		end
		return v;
	endfunction

	// rounded num/den in Q7.16, ties away from zero
	function automatic logic [23:0] texcoord_quotient(longint num, longint den);
		longint n, an, ad, q;
		bit neg;
		if (den == 0) begin
			return num > 0 ? 24'h7FFFFF : (num < 0 ? 24'h800000 : 24'h0);
		end
		n = num * 65536;
		neg = (n < 0) != (den < 0);
		an = n < 0 ? -n : n;
		ad = den < 0 ? -den : den;
		q = (2 * an + ad) / (2 * ad);
		if (q > SMAX + 1) begin
			q = SMAX + 1;
		end
		q = clamp24(neg ? -q : q);
		return q[23:0];
	endfunction

	task automatic add_quad(logic list, longint sx, longint sy, longint sw, longint sh,
			longint rx, longint ry, longint rw, longint rh, longint th, bit last);
		longint nax, nbx, nay, nby, x1, x2, y1, y2;
		logic [23:0] ax, bx, ay, by, cx, dx, cy, dy;
		vertex_t v;
		nax = 2 * (sx + sw - rx) - rw;
		nbx = 2 * (sx - rx) - rw;
		nay = 2 * (sy + sh - ry) - rh;
		nby = 2 * (sy - ry) - rh;
		ax = texcoord_quotient(nax, rw);
		bx = texcoord_quotient(nbx, rw);
		ay = texcoord_quotient(nay, rh);
		by = texcoord_quotient(nby, rh);
		cx = texcoord_quotient(nax, rw - 2 * th);
		dx = texcoord_quotient(nbx, rw - 2 * th);
		cy = texcoord_quotient(nay, rh - 2 * th);
		dy = texcoord_quotient(nby, rh - 2 * th);
		x1 = clamp24(sx);
		x2 = clamp24(sx + sw);
		y1 = clamp24(-sy);
		y2 = clamp24(-sy - sh);
		v.list = list;
		v.pend = 1'b0;
		v.rend = 1'b0;
		// corners: right top, right bottom, left bottom, left top
		v.px = x2[23:0]; v.py = y1[23:0]; v.su = cx; v.sv = dy; v.uu = ax; v.uv = by;
		pending_vertices.push_back(v);
		v.py = y2[23:0]; v.sv = cy; v.uv = ay;
		pending_vertices.push_back(v);
		v.px = x1[23:0]; v.su = dx; v.uu = bx;
		pending_vertices.push_back(v);
		v.py = y1[23:0]; v.sv = dy; v.uv = by; v.pend = 1'b1; v.rend = last;
		pending_vertices.push_back(v);
	endtask

	task automatic build_request_vertices(shape_req_t q);
		longint x, y, w, h, r, rr, th;
		x = q.x; y = q.y; w = q.w; h = q.h; r = q.r; th = q.th;
		rr = 2 * r;
		case (q.func)
			sqvg_pkg::FUNC_RECT, sqvg_pkg::FUNC_ELLIPSE: begin
				add_quad(q.func == sqvg_pkg::FUNC_ELLIPSE, x, y, w, h, x, y, w, h, th, 1'b1);
			end
			sqvg_pkg::FUNC_RECT_SLICE, sqvg_pkg::FUNC_ELLIPSE_SLICE: begin
				add_quad(q.func == sqvg_pkg::FUNC_ELLIPSE_SLICE, longint'(q.sx),
					longint'(q.sy), longint'(q.sw), longint'(q.sh), x, y, w, h, th, 1'b1);
			end
			sqvg_pkg::FUNC_ROUNDED: begin
				add_quad(sqvg_pkg::LIST_ELLIPSE, x, y, r, r, x, y, rr, rr, th, 1'b0);
				add_quad(sqvg_pkg::LIST_ELLIPSE, x + w - r, y, r, r, x + w - rr, y, rr, rr,
					th, 1'b0);
				add_quad(sqvg_pkg::LIST_ELLIPSE, x, y + h - r, r, r, x, y + h - rr, rr, rr,
					th, 1'b0);
				add_quad(sqvg_pkg::LIST_ELLIPSE, x + w - r, y + h - r, r, r,
					x + w - rr, y + h - rr, rr, rr, th, 1'b0);
				add_quad(sqvg_pkg::LIST_RECT, x + r, y, w - rr, r, x, y, w, h, th, 1'b0);
				add_quad(sqvg_pkg::LIST_RECT, x + r, y + h - r, w - rr, r, x, y, w, h, th,
					1'b0);
				add_quad(sqvg_pkg::LIST_RECT, x, y + r, w, h - rr, x, y, w, h, th, 1'b1);
			end
			default: begin
			end
		endcase
	endtask

	function automatic shape_req_t mk(logic [2:0] f, longint x, longint y, longint w,
			longint h, longint sx, longint sy, longint sw, longint sh, longint r,
			longint th);
		shape_req_t q;
		q.func = f; q.x = 24'(x); q.y = 24'(y); q.w = 23'(w); q.h = 23'(h);
		q.sx = 24'(sx); q.sy = 24'(sy); q.sw = 23'(sw); q.sh = 23'(sh);
		q.r = 23'(r); q.th = 23'(th);
		return q;
	endfunction

	function automatic vertex_t vx(logic l, longint px, longint py, longint su, longint sv,
			longint uu, longint uv);
		vertex_t v;
		v.list = l; v.px = 24'(px); v.py = 24'(py); v.su = 24'(su); v.sv = 24'(sv);
		v.uu = 24'(uu); v.uv = 24'(uv);
		v.pend = 1'b0; v.rend = 1'b0;
		return v;
	endfunction

	task automatic add_row(shape_req_t q, bit has_exp, vertex_t v);
		table_row_t t;
		t.req = q; t.has_exp = has_exp; t.first = v;
		directed.push_back(t);
	endtask

	function automatic int pick_gap();
		int k;
		k = $urandom_range(0, 99);
		if (k < 60) begin
			return 0;
		end
		if (k < 94) begin
			return $urandom_range(1, 4);
		end
		return $urandom_range(10, 60);
	endfunction

	function automatic logic [22:0] rand_size(bit full);
		return full ? 23'($urandom()) : 23'($urandom_range(1, 4096));
	endfunction

	function automatic shape_req_t rand_req();
		shape_req_t q;
		bit full;
		int k;
		full = $urandom_range(0, 4) == 0;
		k = $urandom_range(0, 99);
		q.func = k < 96 ? 3'($urandom_range(0, 4)) : 3'($urandom_range(5, 7));
		q.x = full ? 24'($urandom()) : 24'($signed($urandom_range(0, 8192)) - 4096);
		q.y = full ? 24'($urandom()) : 24'($signed($urandom_range(0, 8192)) - 4096);
		q.w = rand_size(full);
		q.h = rand_size(full);
		if (q.w == 23'd0) q.w = 23'd1;
		if (q.h == 23'd0) q.h = 23'd1;
		q.sx = full ? 24'($urandom()) : q.x + 24'($signed($urandom_range(0, 512)) - 128);
		q.sy = full ? 24'($urandom()) : q.y + 24'($signed($urandom_range(0, 512)) - 128);
		q.sw = $urandom_range(0, 9) == 0 ? 23'd0 : rand_size(full);
		q.sh = $urandom_range(0, 9) == 0 ? 23'd0 : rand_size(full);
		k = $urandom_range(0, 9);
		q.r = k == 0 ? 23'd0 : (k < 7 ? q.w / 23'($urandom_range(2, 8)) : rand_size(full));
		k = $urandom_range(0, 9);
		case (k)
			0: q.th = 23'd0;
			1: q.th = q.w >> 1;
			2: q.th = q.h >> 1;
			3: q.th = q.r;
			4: q.th = rand_size(1'b1);
			default: q.th = 23'($urandom_range(0, 64));
		endcase
		return q;
	endfunction

	task automatic check_field(string name, logic [23:0] e, logic [23:0] a);
		if (e !== a) begin
			$error("%s: expected %0h, actual %0h", name, e, a);
			fails++;
		end
	endtask

	// the vertex transfer happens at the next rising edge; outputs are stable here
	always @(negedge clk) begin
		vertex_t e;
		if (arst_n) begin
			if ((req_valid && req_ready) || (vtx_valid && vtx_ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= IDLE_MAX) begin
				$display("[shape_quad_vertex_generator_top] ERROR");
				$finish;
			end
			if (vtx_valid && vtx_ready) begin
				if (pending_vertices.size() == 0) begin
					$error("vertex: expected none, actual pos %0h,%0h", pos_x, pos_y);
					fails++;
				end else begin
					e = pending_vertices.pop_front();
					check_field("list_select", 24'(e.list), 24'(list_select));
					check_field("pos_x", e.px, pos_x);
					check_field("pos_y", e.py, pos_y);
					check_field("scaled_u", e.su, scaled_u);
					check_field("scaled_v", e.sv, scaled_v);
					check_field("unit_u", e.uu, unit_u);
					check_field("unit_v", e.uv, unit_v);
					check_field("primitive_end", 24'(e.pend), 24'(primitive_end));
					check_field("run_end", 24'(e.rend), 24'(run_end));
				end
			end
		end
	end

	// vertex side: random stalls, burst stretches, one long hold-off
	initial begin
		int n, taken, loops;
		bit burst, held;
		vtx_ready = 1'b0;
		taken = 0;
		loops = 0;
		burst = 1'b0;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			if (loops % 64 == 0) begin
				burst = $urandom_range(0, 3) == 0;
			end
			loops++;
			n = burst ? 0 : pick_gap();
			if (!held && taken > 2000) begin
				n = HOLD_LEN;
				held = 1'b1;
			end
			if (n > 0) begin
				vtx_ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			vtx_ready <= 1'b1;
			@(posedge clk);
			if (vtx_valid && vtx_ready) begin
				taken++;
			end
		end
	end

	initial begin
		shape_req_t q;
		int g, base;
		bit hit, burst;
		vertex_t dummy;
		arst_n = 1'b0;
		req_valid = 1'b0;
		func = '0; rect_x = '0; rect_y = '0; rect_w = '0; rect_h = '0;
		slice_x = '0; slice_y = '0; slice_w = '0; slice_h = '0;
		corner_radius = '0; stroke_width = '0;
		dummy = vx(1'b0, 0, 0, 0, 0, 0, 0);

		add_row(mk(sqvg_pkg::FUNC_RECT, 0, 0, 256, 256, 0, 0, 0, 0, 0, 0), 1,
			vx(sqvg_pkg::LIST_RECT, 256, 0, 65536, -65536, 65536, -65536));
		// thickness of exactly half the size
		add_row(mk(sqvg_pkg::FUNC_ELLIPSE, 0, 0, 256, 256, 0, 0, 0, 0, 0, 128), 1,
			vx(sqvg_pkg::LIST_ELLIPSE, 256, 0, SMAX, SMIN, 65536, -65536));
		// position extremes saturate
		add_row(mk(sqvg_pkg::FUNC_RECT, SMAX, SMIN, SMAX, SMAX, 0, 0, 0, 0, 0, 0), 1,
			vx(sqvg_pkg::LIST_RECT, SMAX, SMAX, 65536, -65536, 65536, -65536));
		add_row(mk(sqvg_pkg::FUNC_ELLIPSE, SMIN, SMAX, 1, 1, 0, 0, 0, 0, 0, 0), 0, dummy);
		add_row(mk(sqvg_pkg::FUNC_RECT, SMIN, SMIN, 1, SMAX, 0, 0, 0, 0, 0, SMAX), 0, dummy);
		add_row(mk(sqvg_pkg::FUNC_RECT_SLICE, 0, 0, 512, 256, 128, 64, 100, 50, 0, 10), 0,
			dummy);
		add_row(mk(sqvg_pkg::FUNC_ELLIPSE_SLICE, -100, 50, 300, 300, 0, 0, 0, 0, 0, 20), 0,
			dummy);
		add_row(mk(sqvg_pkg::FUNC_RECT_SLICE, 0, 0, 1, 1, SMAX, SMIN, SMAX, SMAX, 0, 0), 0,
			dummy);
		add_row(mk(sqvg_pkg::FUNC_ELLIPSE_SLICE, SMAX, SMAX, SMAX, SMAX, SMIN, SMIN, 0, SMAX,
			0, 1), 0, dummy);
		// thickness above half the size flips the scaled sign
		add_row(mk(sqvg_pkg::FUNC_RECT, 10, 20, 100, 100, 0, 0, 0, 0, 0, 80), 0, dummy);
		add_row(mk(sqvg_pkg::FUNC_ROUNDED, 0, 0, 1024, 512, 0, 0, 0, 0, 64, 8), 0, dummy);
		// zero radius gives zero corner references
		add_row(mk(sqvg_pkg::FUNC_ROUNDED, 100, -100, 300, 200, 0, 0, 0, 0, 0, 0), 0, dummy);
		add_row(mk(sqvg_pkg::FUNC_ROUNDED, 0, 0, 100, 100, 0, 0, 0, 0, 200, 50), 0, dummy);
		add_row(mk(sqvg_pkg::FUNC_ROUNDED, SMAX, SMIN, SMAX, SMAX, 0, 0, 0, 0, SMAX, SMAX), 0,
			dummy);
		add_row(mk(sqvg_pkg::FUNC_ROUNDED, SMIN, SMAX, 1, 1, 0, 0, 0, 0, 1, 1), 0, dummy);
		add_row(mk(3'd5, 0, 0, 1, 1, 0, 0, 0, 0, 0, 0), 0, dummy);
		add_row(mk(3'd6, 1, 1, 2, 2, 0, 0, 0, 0, 0, 0), 0, dummy);
		add_row(mk(3'd7, -1, -1, SMAX, SMAX, 0, 0, 0, 0, 0, 0), 0, dummy);
		add_row(mk(sqvg_pkg::FUNC_RECT, 0, 0, 256, 256, 0, 0, 0, 0, 0, 0), 0, dummy);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		burst = 1'b0;
		for (int i = 0; i < directed.size() + N_RANDOM; i++) begin
			if (i < directed.size()) begin
				q = directed[i].req;
			end else begin
				q = rand_req();
			end
			if (i % 50 == 0) begin
				burst = $urandom_range(0, 2) == 0;
			end
			g = burst ? 0 : pick_gap();
			if (g > 0) begin
				req_valid <= 1'b0;
				repeat (g) @(posedge clk);
			end
			func <= q.func; rect_x <= q.x; rect_y <= q.y; rect_w <= q.w; rect_h <= q.h;
			slice_x <= q.sx; slice_y <= q.sy; slice_w <= q.sw; slice_h <= q.sh;
			corner_radius <= q.r; stroke_width <= q.th;
			req_valid <= 1'b1;
			do begin
				@(negedge clk);
				hit = req_ready;
				@(posedge clk);
			end while (!hit);
			base = pending_vertices.size();
			build_request_vertices(q);
			if (i < directed.size() && directed[i].has_exp) begin
				pending_vertices[base] = directed[i].first;
			end
		end
		req_valid <= 1'b0;

		while (pending_vertices.size() != 0) begin
			@(posedge clk);
		end
		repeat (40) @(posedge clk);
		if (fails == 0) begin
			$display("[shape_quad_vertex_generator_top] OK");
		end else begin
			$display("[shape_quad_vertex_generator_top] ERROR");
		end
		$finish;
	end

endmodule

[files.f]
rtl/core/sqvg_pkg.sv
rtl/core/sqvg_seq.sv
rtl/core/sqvg_prep.sv
rtl/core/sqvg_div.sv
rtl/core/shape_quad_vertex_generator_top.sv
sim/testbench.sv
